### rtl/core/sva_pkg.sv
package sva_pkg;

  // Batch limits and number format.
  localparam int MAX_SAMPLES = 65536;
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 8;

  // Port widths.
  localparam int IN_W     = 16;
  localparam int VAR_W    = 39;
  localparam int CNT_W    = 17;
  localparam int STATUS_W = 2;

  // Accumulator widths, large enough for any batch up to the sample limit.
  localparam int SUM_W  = 33;
  localparam int SQ_W   = 47;
  localparam int MAG_W  = SUM_W - 1;
  localparam int XSQ_W  = 2 * SAMPLE_BITS;

  // Datapath widths of the shared arithmetic unit.
  localparam int PROD_W = CNT_W + SQ_W;
  localparam int ALU_W  = PROD_W;
  localparam int DEN_W  = 2 * CNT_W;
  localparam int REM_W  = DEN_W + 1;
  localparam int DIV_W  = PROD_W + FRAC_BITS;
  localparam int STEP_W = $clog2(DIV_W + 1);

  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FEW  = 2'd1,
    ST_OVER = 2'd2
  } status_t;

  // Totals of one finished batch, handed to the sequencer.
  typedef struct packed {
    logic                    start;
    logic                    overflow;
    logic [CNT_W-1:0]        count;
    logic signed [SUM_W-1:0] sum;
    logic [SQ_W-1:0]         sum_sq;
  } batch_t;

  // One finished result, handed to the output register.
  typedef struct packed {
    logic             valid;
    logic [VAR_W-1:0] variance;
    logic [CNT_W-1:0] count;
    status_t          status;
  } res_t;

endpackage

### rtl/core/sva_alu.sv
// Shared adder/subtractor. The top bit of the result is the carry, or the
// borrow on a subtraction.
module sva_alu (
  input  logic [sva_pkg::ALU_W-1:0] a,
  input  logic [sva_pkg::ALU_W-1:0] b,
  input  logic                      sub,
  output logic [sva_pkg::ALU_W:0]   res
);

  always_comb begin
    if (sub) begin
      res = {1'b0, a} - {1'b0, b};
    end else begin
      res = {1'b0, a} + {1'b0, b};
    end
  end

endmodule

### rtl/core/sva_accum.sv
// Sample pipeline and running totals. Each request is squared in a
// registered multiplier and then added into the count, sum and sum of squares.
module sva_accum (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       fire,
  input  logic [sva_pkg::IN_W-1:0]   sample,
  input  logic                       last,
  output sva_pkg::batch_t            batch,
  output logic                       hold
);

  logic                                  s1_valid;
  logic                                  s1_last;
  logic signed [sva_pkg::SAMPLE_BITS-1:0] s1_x;
  logic [sva_pkg::SAMPLE_BITS-1:0]       s1_mag;

  logic                                  s2_valid;
  logic                                  s2_last;
  logic signed [sva_pkg::SAMPLE_BITS-1:0] s2_x;
  logic [sva_pkg::XSQ_W-1:0]             s2_sq;

  logic [sva_pkg::CNT_W-1:0]             count;
  logic signed [sva_pkg::SUM_W-1:0]      sum_acc;
  logic [sva_pkg::SQ_W-1:0]              sum_sq_acc;
  logic                                  overflow_flag;

  logic signed [sva_pkg::SAMPLE_BITS-1:0] in_x;
  logic                                  room;
  logic [sva_pkg::CNT_W-1:0]             count_next;
  logic signed [sva_pkg::SUM_W-1:0]      sum_next;
  logic [sva_pkg::SQ_W-1:0]              sum_sq_next;
  logic                                  overflow_next;

  // Bits above the sample width are ignored.
  assign in_x = $signed(sample[sva_pkg::SAMPLE_BITS-1:0]);

  assign room = (count != sva_pkg::CNT_W'(sva_pkg::MAX_SAMPLES));

  always_comb begin
    count_next    = count;
    sum_next      = sum_acc;
    sum_sq_next   = sum_sq_acc;
    overflow_next = overflow_flag;
    if (s2_valid) begin
      if (room) begin
        count_next  = count + sva_pkg::CNT_W'(1);
        sum_next    = sum_acc + sva_pkg::SUM_W'(s2_x);
        sum_sq_next = sum_sq_acc + sva_pkg::SQ_W'(s2_sq);
      end else begin
        overflow_next = 1'b1;
      end
    end
  end

  assign hold = (s1_valid & s1_last) | (s2_valid & s2_last) | batch.start;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      count         <= '0;
      sum_acc       <= '0;
      sum_sq_acc    <= '0;
      overflow_flag <= 1'b0;
      batch.start   <= 1'b0;
    end else begin
      s1_valid    <= fire;
      s2_valid    <= s1_valid;
      batch.start <= s2_valid & s2_last;
      if (s2_valid & s2_last) begin
        count         <= '0;
        sum_acc       <= '0;
        sum_sq_acc    <= '0;
        overflow_flag <= 1'b0;
      end else begin
        count         <= count_next;
        sum_acc       <= sum_next;
        sum_sq_acc    <= sum_sq_next;
        overflow_flag <= overflow_next;
      end
    end
    s1_last <= last;
    s1_x    <= in_x;
    s1_mag  <= in_x[sva_pkg::SAMPLE_BITS-1] ? sva_pkg::SAMPLE_BITS'(-in_x)
                                            : sva_pkg::SAMPLE_BITS'(in_x);
    s2_last <= s1_last;
    s2_x    <= s1_x;
    s2_sq   <= sva_pkg::XSQ_W'(s1_mag) * sva_pkg::XSQ_W'(s1_mag);
    batch.overflow <= overflow_next;
    batch.count    <= count_next;
    batch.sum      <= sum_next;
    batch.sum_sq   <= sum_sq_next;
  end

endmodule

### rtl/core/sva_seq.sv
// Sequencer that drives the shared adder through the end-of-batch math:
// absolute sum, three shift-and-add products, one subtraction and a
// restoring division that yields one quotient bit per cycle.
module sva_seq (
  input  logic            clk,
  input  logic            rst,
  input  sva_pkg::batch_t batch,
  input  logic            out_free,
  output sva_pkg::res_t   res,
  output logic            busy
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ABS,
    S_MUL_NS,
    S_MUL_SS,
    S_SUB,
    S_MUL_DEN,
    S_DIV,
    S_FIN
  } state_t;

  state_t                           state;
  logic [sva_pkg::CNT_W-1:0]        cnt_r;
  logic signed [sva_pkg::SUM_W-1:0] sum_r;
  logic [sva_pkg::SQ_W-1:0]         sq_r;
  logic [sva_pkg::MAG_W-1:0]        mag_r;
  logic [sva_pkg::PROD_W-1:0]       prod_r;
  logic [sva_pkg::PROD_W-1:0]       mcand_r;
  logic [sva_pkg::MAG_W-1:0]        mplier_r;
  logic [sva_pkg::PROD_W-1:0]       num_r;
  logic [sva_pkg::DEN_W-1:0]        den_r;
  logic [sva_pkg::DIV_W-1:0]        dvd_r;
  logic [sva_pkg::DEN_W-1:0]        rem_r;
  logic [sva_pkg::DIV_W-1:0]        quo_r;
  logic [sva_pkg::STEP_W-1:0]       step_r;
  logic [sva_pkg::VAR_W-1:0]        var_r;
  sva_pkg::status_t                 status_r;

  logic [sva_pkg::ALU_W-1:0]        alu_a;
  logic [sva_pkg::ALU_W-1:0]        alu_b;
  logic                             alu_sub;
  logic [sva_pkg::ALU_W:0]          alu_res;
  logic [sva_pkg::REM_W-1:0]        rem_sh;
  logic [sva_pkg::PROD_W-1:0]       p_fin;
  logic                             q_bit;
  logic [sva_pkg::DIV_W-1:0]        q_fin;
  logic                             last_step;

  sva_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res)
  );

  assign rem_sh    = {rem_r, dvd_r[sva_pkg::DIV_W-1]};
  assign p_fin     = mplier_r[0] ? alu_res[sva_pkg::PROD_W-1:0] : prod_r;
  assign q_bit     = ~alu_res[sva_pkg::ALU_W];
  assign q_fin     = {quo_r[sva_pkg::DIV_W-2:0], q_bit};
  assign last_step = (step_r == sva_pkg::STEP_W'(1));

  always_comb begin
    alu_a   = prod_r;
    alu_b   = mcand_r;
    alu_sub = 1'b0;
    unique case (state)
      S_ABS: begin
        alu_a   = '0;
        alu_b   = sva_pkg::ALU_W'(sum_r);
        alu_sub = 1'b1;
      end
      S_SUB: begin
        alu_a   = num_r;
        alu_b   = prod_r;
        alu_sub = 1'b1;
      end
      S_DIV: begin
        alu_a   = sva_pkg::ALU_W'(rem_sh);
        alu_b   = sva_pkg::ALU_W'(den_r);
        alu_sub = 1'b1;
      end
      default: begin
      end
    endcase
  end

  assign busy         = (state != S_IDLE);
  assign res.valid    = (state == S_FIN) & out_free;
  assign res.variance = var_r;
  assign res.count    = cnt_r;
  assign res.status   = status_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (batch.start) begin
            cnt_r <= batch.count;
            sum_r <= batch.sum;
            sq_r  <= batch.sum_sq;
            var_r <= '0;
            if (batch.overflow) begin
              status_r <= sva_pkg::ST_OVER;
              state    <= S_FIN;
            end else if (batch.count < sva_pkg::CNT_W'(2)) begin
              status_r <= sva_pkg::ST_FEW;
              state    <= S_FIN;
            end else begin
              status_r <= sva_pkg::ST_OK;
              state    <= S_ABS;
            end
          end
        end
        S_ABS: begin
          mag_r    <= sum_r[sva_pkg::SUM_W-1] ? alu_res[sva_pkg::MAG_W-1:0]
                                              : sum_r[sva_pkg::MAG_W-1:0];
          prod_r   <= '0;
          mcand_r  <= sva_pkg::PROD_W'(sq_r);
          mplier_r <= sva_pkg::MAG_W'(cnt_r);
          step_r   <= sva_pkg::STEP_W'(sva_pkg::CNT_W);
          state    <= S_MUL_NS;
        end
        S_MUL_NS, S_MUL_SS, S_MUL_DEN: begin
          if (!last_step) begin
            prod_r   <= p_fin;
            mcand_r  <= mcand_r << 1;
            mplier_r <= mplier_r >> 1;
            step_r   <= step_r - sva_pkg::STEP_W'(1);
          end else if (state == S_MUL_NS) begin
            num_r    <= p_fin;
            prod_r   <= '0;
            mcand_r  <= sva_pkg::PROD_W'(mag_r);
            mplier_r <= mag_r;
            step_r   <= sva_pkg::STEP_W'(sva_pkg::MAG_W);
            state    <= S_MUL_SS;
          end else if (state == S_MUL_SS) begin
            prod_r <= p_fin;
            state  <= S_SUB;
          end else begin
            den_r  <= p_fin[sva_pkg::DEN_W-1:0];
            dvd_r  <= sva_pkg::DIV_W'(num_r) << sva_pkg::FRAC_BITS;
            rem_r  <= '0;
            quo_r  <= '0;
            step_r <= sva_pkg::STEP_W'(sva_pkg::DIV_W);
            state  <= S_DIV;
          end
        end
        S_SUB: begin
          num_r    <= alu_res[sva_pkg::PROD_W-1:0];
          prod_r   <= '0;
          mcand_r  <= sva_pkg::PROD_W'(cnt_r - sva_pkg::CNT_W'(1));
          mplier_r <= sva_pkg::MAG_W'(cnt_r);
          step_r   <= sva_pkg::STEP_W'(sva_pkg::CNT_W);
          state    <= S_MUL_DEN;
        end
        S_DIV: begin
          rem_r  <= q_bit ? alu_res[sva_pkg::DEN_W-1:0] : rem_sh[sva_pkg::DEN_W-1:0];
          quo_r  <= q_fin;
          dvd_r  <= dvd_r << 1;
          step_r <= step_r - sva_pkg::STEP_W'(1);
          if (last_step) begin
            // Saturate when the scaled variance does not fit the output.
            if (q_fin[sva_pkg::DIV_W-1:sva_pkg::VAR_W] != '0) begin
              var_r <= '1;
            end else begin
              var_r <= q_fin[sva_pkg::VAR_W-1:0];
            end
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### rtl/core/sample_variance_accumulator.sv
// Channel  | Handshake                  | Payload
// ---------+----------------------------+----------------------------------
// input    | in_valid / in_stall        | sample, last
// output   | out_valid / out_stall      | variance_q, sample_count, status
//
// A sample that is not the last of its batch leaves in_stall low; while no
// batch end is in flight or being computed, a request can follow every cycle.
// A request with last set holds off input while it drains the squaring
// pipeline (s1, s2 and the batch register), while the shared adder runs an
// absolute value, 17 + 32 + 17 multiply steps, a subtraction and 72 division
// steps, and until the result is handed over once the output is free. A batch
// with too few samples or past the limit skips the arithmetic.
// Reset is synchronous and active high; it clears the totals, the pipeline and
// the sequencer. The finished result sits in an output register, so a stalled
// output does not hold off input until the next batch result is ready.
//
// The unbiased sample variance is computed exactly as
// (n * sum_sq - sum^2) / (n * (n - 1)), with FRAC_BITS fraction bits,
// truncated and saturated to the width of variance_q. Batches with fewer than
// two samples, or with samples beyond the limit, report a status and a zero
// variance instead.
module sample_variance_accumulator (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sva_pkg::IN_W-1:0]      sample,
  input  logic                          last,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sva_pkg::VAR_W-1:0]     variance_q,
  output logic [sva_pkg::CNT_W-1:0]     sample_count,
  output logic [sva_pkg::STATUS_W-1:0]  status
);

  sva_pkg::batch_t batch;
  sva_pkg::res_t   res;
  logic            acc_hold;
  logic            seq_busy;
  logic            in_fire;
  logic            out_free;

  // Input is held off while a batch end is in flight or being computed.
  assign in_stall = acc_hold | seq_busy;
  assign in_fire  = in_valid & ~in_stall;

  // The output register can take a new result when it is empty or draining.
  assign out_free = ~out_valid | ~out_stall;

  sva_accum u_accum (
    .clk    (clk),
    .rst    (rst),
    .fire   (in_fire),
    .sample (sample),
    .last   (last),
    .batch  (batch),
    .hold   (acc_hold)
  );

  sva_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .batch    (batch),
    .out_free (out_free),
    .res      (res),
    .busy     (seq_busy)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (~out_stall) begin
      out_valid <= 1'b0;
    end
    if (res.valid) begin
      variance_q   <= res.variance;
      sample_count <= res.count;
      status       <= res.status;
    end
  end

endmodule
